// ===== rtl/vgl_pkg.sv =====
// Shared types and constants of the Voronoi grain labeler.
// No dependencies; vgl_dist_unit, the core and the checker import this package.
`default_nettype none

package vgl_pkg;

    // Default sizes of the grain store and of the datapath.
    localparam int VGL_MAX_GRAINS = 256;
    localparam int VGL_COORD_BITS = 24;
    localparam int VGL_INDEX_BITS = 10;

    // Fixed widths of the port fields.
    localparam int CELL_W  = 14;
    localparam int COUNT_W = 9;
    localparam int SEED_W  = 24;
    localparam int CIDX_W  = 10;
    localparam int ANISO_W = 31;
    localparam int AXIS_W  = 16;
    localparam int DIST_W  = 50;
    localparam int PAY_W   = ANISO_W + 3 * AXIS_W;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    // Configuration port.
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE_X = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE_Y = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE_Z = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAIN_COUNT = 4'd3;

    // Input actions.
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // Control that travels alongside each grain through the distance unit.
    typedef struct packed {
        logic valid;
        logic last;
    } t_dist_ctl;

endpackage

`default_nettype wire

// ===== rtl/vgl_grain_mem.sv =====
// Grain store: one write port, one read port with registered read data.
// Depends on nothing but its parameters.
`default_nettype none

module vgl_grain_mem #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8,
    parameter int DATA_W = 151
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/vgl_dist_unit.sv =====
// Pipelined squared-distance unit: absolute difference, square, sum with saturation.
// Takes one grain per cycle; depends on vgl_pkg.
`default_nettype none

module vgl_dist_unit
    import vgl_pkg::*;
#(
    parameter int CTR_W   = 24,
    parameter int COORD_W = 24,
    parameter int TAG_W   = 87
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_dist_ctl          i_ctl,
    input  wire logic [TAG_W-1:0]   i_tag,
    input  wire logic [CTR_W-1:0]   i_ctr_x,
    input  wire logic [CTR_W-1:0]   i_ctr_y,
    input  wire logic [CTR_W-1:0]   i_ctr_z,
    input  wire logic [COORD_W-1:0] i_seed_x,
    input  wire logic [COORD_W-1:0] i_seed_y,
    input  wire logic [COORD_W-1:0] i_seed_z,
    output t_dist_ctl               o_ctl,
    output logic      [TAG_W-1:0]   o_tag,
    output logic      [DIST_W-1:0]  o_dist
);

    localparam int DIFF_W = (CTR_W > COORD_W) ? CTR_W : COORD_W;
    localparam int SQ_W   = 2 * DIFF_W;
    localparam int SUM_W  = SQ_W + 2;
    localparam int WIDE_W = (SUM_W > DIST_W) ? SUM_W : DIST_W;

    t_dist_ctl r_ctl1, r_ctl2, r_ctl3;
    logic [TAG_W-1:0]  r_tag1, r_tag2, r_tag3;
    logic [DIFF_W-1:0] r_dx, r_dy, r_dz;
    logic [SQ_W-1:0]   r_sx, r_sy, r_sz;
    logic [DIST_W-1:0] r_dist;

    function automatic logic [DIFF_W-1:0] abs_diff(input logic [DIFF_W-1:0] a,
                                                   input logic [DIFF_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    logic [DIFF_W-1:0] cx, cy, cz, sx, sy, sz;
    logic [WIDE_W-1:0] sum;

    always_comb begin
        cx  = DIFF_W'(i_ctr_x);
        cy  = DIFF_W'(i_ctr_y);
        cz  = DIFF_W'(i_ctr_z);
        sx  = DIFF_W'(i_seed_x);
        sy  = DIFF_W'(i_seed_y);
        sz  = DIFF_W'(i_seed_z);
        sum = WIDE_W'(r_sx) + WIDE_W'(r_sy) + WIDE_W'(r_sz);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
            r_ctl3 <= '0;
        end else begin
            r_ctl1 <= i_ctl;
            r_ctl2 <= r_ctl1;
            r_ctl3 <= r_ctl2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag1 <= i_tag;
        r_dx   <= abs_diff(cx, sx);
        r_dy   <= abs_diff(cy, sy);
        r_dz   <= abs_diff(cz, sz);
        r_tag2 <= r_tag1;
        r_sx   <= SQ_W'(r_dx) * SQ_W'(r_dx);
        r_sy   <= SQ_W'(r_dy) * SQ_W'(r_dy);
        r_sz   <= SQ_W'(r_dz) * SQ_W'(r_dz);
        r_tag3 <= r_tag2;
        r_dist <= (sum > WIDE_W'(DIST_MAX)) ? DIST_MAX : sum[DIST_W-1:0];
    end

    assign o_ctl  = r_ctl3;
    assign o_tag  = r_tag3;
    assign o_dist = r_dist;

endmodule

`default_nettype wire

// ===== rtl/voronoi_grain_labeler_core.sv =====
// Top level of the Voronoi grain labeler: sequencer, grain store and nearest-seed search.
// Depends on vgl_pkg, vgl_grain_mem and vgl_dist_unit.
//
//  channel   signals                          direction  moves
//  input     i_valid / o_ready, i_* fields    in         load or query word
//  output    o_valid / i_ready, o_* fields    out        one result word per query
//  config    i_cfg_valid / o_cfg_ready        in         register index and data
//
// A query word passes through the states S_CTR, S_RUN, S_WAIT and S_FIN from accept to
// result; in S_RUN the grain store delivers one seed per cycle, for each of the N grains in use,
// to the distance pipeline, which is three stages deep.
// The block takes no word while a query is in progress; a result waiting at the
// output does not hold back the next word, only the next result.
// Reset is synchronous and active low; the grain store holds no reset value.
`default_nettype none

module voronoi_grain_labeler_core
    import vgl_pkg::*;
#(
    parameter int MAX_GRAINS = VGL_MAX_GRAINS,
    parameter int COORD_BITS = VGL_COORD_BITS,
    parameter int INDEX_BITS = VGL_INDEX_BITS
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic                   i_action,
    input  wire logic [7:0]             i_grain_slot,
    input  wire logic [SEED_W-1:0]      i_seed_x,
    input  wire logic [SEED_W-1:0]      i_seed_y,
    input  wire logic [SEED_W-1:0]      i_seed_z,
    input  wire logic signed [31:0]     i_grain_anisotropy,
    input  wire logic signed [AXIS_W-1:0] i_axis_x,
    input  wire logic signed [AXIS_W-1:0] i_axis_y,
    input  wire logic signed [AXIS_W-1:0] i_axis_z,
    input  wire logic [CIDX_W-1:0]      i_cell_i,
    input  wire logic [CIDX_W-1:0]      i_cell_j,
    input  wire logic [CIDX_W-1:0]      i_cell_k,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic [7:0]                  o_nearest_grain,
    output logic [ANISO_W-1:0]          o_out_anisotropy,
    output logic signed [AXIS_W-1:0]    o_out_axis_x,
    output logic signed [AXIS_W-1:0]    o_out_axis_y,
    output logic signed [AXIS_W-1:0]    o_out_axis_z,
    output logic [DIST_W-1:0]           o_distance_squared
);

    localparam int IDX_W   = (INDEX_BITS < CIDX_W) ? INDEX_BITS : CIDX_W;
    localparam int COORD_W = (COORD_BITS < SEED_W) ? COORD_BITS : SEED_W;
    localparam int CTR_W   = IDX_W + CELL_W;
    localparam int GIDX_W  = (MAX_GRAINS > 1) ? $clog2(MAX_GRAINS) : 1;
    localparam int CNT_LW  = $clog2(MAX_GRAINS + 1);
    localparam int CNT_W   = (CNT_LW > COUNT_W) ? CNT_LW : COUNT_W;
    localparam int SLOT_W  = (GIDX_W + 1 > 9) ? GIDX_W + 1 : 9;
    localparam int OIDX_W  = (GIDX_W > 8) ? GIDX_W : 8;
    localparam int ENTRY_W = PAY_W + 3 * COORD_W;
    localparam int TAG_W   = GIDX_W + PAY_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CTR  = 3'd1;
    localparam logic [2:0] S_RUN  = 3'd2;
    localparam logic [2:0] S_WAIT = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0] r_state, n_state;

    logic [CELL_W-1:0]  r_cell_x, r_cell_y, r_cell_z;
    logic [COUNT_W-1:0] r_grain_count;

    logic [IDX_W-1:0]  r_idx_i, r_idx_j, r_idx_k;
    logic [CTR_W-1:0]  r_ctr_x, r_ctr_y, r_ctr_z;
    logic [GIDX_W-1:0] r_gidx;
    t_dist_ctl         r_iss_ctl, n_iss_ctl;
    logic [GIDX_W-1:0] r_iss_idx;

    logic [DIST_W-1:0] r_best_d;
    logic [TAG_W-1:0]  r_best_tag;
    logic              r_o_valid, n_o_valid;
    logic [7:0]        r_o_idx;
    logic [PAY_W-1:0]  r_o_pay;
    logic [DIST_W-1:0] r_o_dist;

    // Datapath wires.
    logic              in_acc, is_load, is_query, out_load;
    logic [SLOT_W-1:0] slot_wide;
    logic              we;
    logic [ENTRY_W-1:0] wdata, rdata;
    logic [ANISO_W-1:0] aniso_clip;
    logic [CNT_W-1:0]  cnt_raw, eff_count;
    logic              is_last, issuing;
    logic [CTR_W-1:0]  ctr_x, ctr_y, ctr_z;
    t_dist_ctl         d_ctl;
    logic [TAG_W-1:0]  d_tag, iss_tag;
    logic [DIST_W-1:0] d_dist;
    logic [GIDX_W-1:0] d_idx;
    logic              take_best;
    logic [OIDX_W-1:0] best_idx_wide;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == S_IDLE);

    always_comb begin
        in_acc     = i_valid && o_ready;
        is_load    = in_acc && (i_action == ACT_LOAD);
        is_query   = in_acc && (i_action == ACT_QUERY);
        slot_wide  = SLOT_W'(i_grain_slot);
        we         = is_load && (slot_wide < SLOT_W'(MAX_GRAINS));
        aniso_clip = i_grain_anisotropy[31] ? '0 : i_grain_anisotropy[ANISO_W-1:0];
        wdata      = {aniso_clip, i_axis_z, i_axis_y, i_axis_x,
                      i_seed_z[COORD_W-1:0], i_seed_y[COORD_W-1:0],
                      i_seed_x[COORD_W-1:0]};

        // A count of zero still searches grain 0; a count above the store saturates.
        cnt_raw = CNT_W'(r_grain_count);
        if (cnt_raw == '0) begin
            eff_count = CNT_W'(1);
        end else if (cnt_raw > CNT_W'(MAX_GRAINS)) begin
            eff_count = CNT_W'(MAX_GRAINS);
        end else begin
            eff_count = cnt_raw;
        end
        is_last = (CNT_W'(r_gidx) + CNT_W'(1)) == eff_count;
        issuing = (r_state == S_RUN);

        ctr_x = CTR_W'(r_idx_i) * CTR_W'(r_cell_x) + CTR_W'(r_cell_x >> 1);
        ctr_y = CTR_W'(r_idx_j) * CTR_W'(r_cell_y) + CTR_W'(r_cell_y >> 1);
        ctr_z = CTR_W'(r_idx_k) * CTR_W'(r_cell_z) + CTR_W'(r_cell_z >> 1);

        iss_tag   = {r_iss_idx, rdata[ENTRY_W-1 -: PAY_W]};
        d_idx     = d_tag[TAG_W-1 -: GIDX_W];
        // Grain 0 always seeds the search; later grains win only when strictly nearer.
        take_best = d_ctl.valid && ((d_idx == '0) || (d_dist < r_best_d));
        out_load  = (r_state == S_FIN) && (!r_o_valid || i_ready);
        best_idx_wide = OIDX_W'(r_best_tag[TAG_W-1 -: GIDX_W]);
    end

    always_comb begin
        n_state         = r_state;
        n_iss_ctl.valid = issuing;
        n_iss_ctl.last  = issuing && is_last;
        n_o_valid       = r_o_valid;
        if (r_o_valid && i_ready) begin
            n_o_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (is_query) begin
                    n_state = S_CTR;
                end
            end
            S_CTR: begin
                n_state = S_RUN;
            end
            S_RUN: begin
                if (is_last) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (d_ctl.valid && d_ctl.last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_load) begin
                    n_o_valid = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_iss_ctl     <= '0;
            r_o_valid     <= 1'b0;
            r_cell_x      <= CELL_W'(1);
            r_cell_y      <= CELL_W'(1);
            r_cell_z      <= CELL_W'(1);
            r_grain_count <= COUNT_W'(1);
        end else begin
            r_state   <= n_state;
            r_iss_ctl <= n_iss_ctl;
            r_o_valid <= n_o_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_CELL_SIZE_X: r_cell_x      <= i_cfg_data[CELL_W-1:0];
                    CFG_CELL_SIZE_Y: r_cell_y      <= i_cfg_data[CELL_W-1:0];
                    CFG_CELL_SIZE_Z: r_cell_z      <= i_cfg_data[CELL_W-1:0];
                    CFG_GRAIN_COUNT: r_grain_count <= i_cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_query) begin
            r_idx_i <= i_cell_i[IDX_W-1:0];
            r_idx_j <= i_cell_j[IDX_W-1:0];
            r_idx_k <= i_cell_k[IDX_W-1:0];
        end
        if (r_state == S_CTR) begin
            r_ctr_x <= ctr_x;
            r_ctr_y <= ctr_y;
            r_ctr_z <= ctr_z;
            r_gidx  <= '0;
        end else if (issuing) begin
            r_gidx <= r_gidx + GIDX_W'(1);
        end
        r_iss_idx <= r_gidx;
        if (take_best) begin
            r_best_d   <= d_dist;
            r_best_tag <= d_tag;
        end
        if (out_load) begin
            r_o_idx  <= best_idx_wide[7:0];
            r_o_pay  <= r_best_tag[PAY_W-1:0];
            r_o_dist <= r_best_d;
        end
    end

    vgl_grain_mem #(
        .DEPTH  (MAX_GRAINS),
        .ADDR_W (GIDX_W),
        .DATA_W (ENTRY_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (slot_wide[GIDX_W-1:0]),
        .i_wdata (wdata),
        .i_re    (issuing),
        .i_raddr (r_gidx),
        .o_rdata (rdata)
    );

    vgl_dist_unit #(
        .CTR_W   (CTR_W),
        .COORD_W (COORD_W),
        .TAG_W   (TAG_W)
    ) u_dist (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (r_iss_ctl),
        .i_tag    (iss_tag),
        .i_ctr_x  (r_ctr_x),
        .i_ctr_y  (r_ctr_y),
        .i_ctr_z  (r_ctr_z),
        .i_seed_x (rdata[COORD_W-1:0]),
        .i_seed_y (rdata[2*COORD_W-1:COORD_W]),
        .i_seed_z (rdata[3*COORD_W-1:2*COORD_W]),
        .o_ctl    (d_ctl),
        .o_tag    (d_tag),
        .o_dist   (d_dist)
    );

    assign o_valid            = r_o_valid;
    assign o_nearest_grain    = r_o_idx;
    assign o_out_anisotropy   = r_o_pay[PAY_W-1 -: ANISO_W];
    assign o_out_axis_z       = r_o_pay[3*AXIS_W-1:2*AXIS_W];
    assign o_out_axis_y       = r_o_pay[2*AXIS_W-1:AXIS_W];
    assign o_out_axis_x       = r_o_pay[AXIS_W-1:0];
    assign o_distance_squared = r_o_dist;

endmodule

`default_nettype wire

// ===== rtl/vgl_checker.sv =====
// Port-level checks of the Voronoi grain labeler, attached to the top level by bind.
// Depends on vgl_pkg for field widths and action codes.
`default_nettype none

module vgl_checker
    import vgl_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_valid,
    input wire logic              o_ready,
    input wire logic              i_action,
    input wire logic              o_valid,
    input wire logic              i_ready,
    input wire logic [7:0]        o_nearest_grain,
    input wire logic [DIST_W-1:0] o_distance_squared
);

    // A result word that is not taken holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_nearest_grain)
                                && $stable(o_distance_squared))
        else $error("result word changed while stalled");

    // A query keeps the block busy for at least the next cycle.
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && (i_action == ACT_QUERY) |=> !o_ready)
        else $error("block ready right after a query");

    // A load never produces a result word.
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid && i_valid && o_ready && (i_action == ACT_LOAD) |=> !o_valid)
        else $error("result word after a load");

    // A result only appears at the end of a busy search.
    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(!o_ready))
        else $error("result word without a search");

endmodule

bind voronoi_grain_labeler_core vgl_checker u_vgl_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_valid            (i_valid),
    .o_ready            (o_ready),
    .i_action           (i_action),
    .o_valid            (o_valid),
    .i_ready            (i_ready),
    .o_nearest_grain    (o_nearest_grain),
    .o_distance_squared (o_distance_squared)
);

`default_nettype wire
